@@ rtl/core/vidm_pkg.sv @@
package vidm_pkg;

	// Table and index space sizing.
	localparam int TABLE_SLOTS  = 8192;
	localparam int MAX_VERTICES = 4096;
	localparam int INDEX_BITS   = 21;

	// Fixed widths of the port fields.
	localparam int FIELD_W     = 21;
	localparam int OUT_VTX_W   = 12;

	// Derived sizes. The table size is a power of two.
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int KEY_W       = 3 * INDEX_BITS;
	localparam int VCAP        = (MAX_VERTICES < TABLE_SLOTS) ? MAX_VERTICES : TABLE_SLOTS;
	localparam int NV_W        = $clog2(VCAP + 1);
	localparam int VTX_W       = $clog2(VCAP);
	localparam int EPOCH_W     = 8;

	// Hash multiply: only the low product bits that reach the folded slot are formed.
	localparam int MUL_W       = 26;
	localparam int PROD_W      = 2 * MUL_W;
	localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

	// One table entry. An entry belongs to the current mesh only when its
	// epoch matches the running epoch.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [KEY_W-1:0]   key;
		logic [VTX_W-1:0]   vertex;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

@@ rtl/core/vertex_index_dedup_map.sv @@
// Vertex index deduplication map. Each word in is one triangle corner
// (position, texture and normal index); each word out is the vertex index
// for that triple, with is_new set when the triple was first seen and
// overflow set (index 0) when no room is left. The block takes one corner
// at a time: an accepted corner is hashed, then probes the linear probe
// chain from its home slot one slot after another, and the next corner is
// accepted only once its result word is written. A result word that waits
// for out_ready holds the next corner in its probe step for as long as it
// waits. The time per corner is set by the hash, which forms its three
// partial products one per cycle on a shared 26 by 26 bit multiplier, and
// by the single read port of the slot memory, read once per probe. After
// reset the block runs a clearing pass over all 8192 slots of the slot
// memory before it accepts a corner. A clear_map only advances the mesh
// epoch and restarts the vertex count, except once every 255 clears,
// when the epoch wraps and the same clearing pass runs first.
module vertex_index_dedup_map (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [vidm_pkg::FIELD_W-1:0]   position_index,
	input  logic [vidm_pkg::FIELD_W-1:0]   texcoord_index,
	input  logic [vidm_pkg::FIELD_W-1:0]   normal_index,
	input  logic                           clear_map,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [vidm_pkg::OUT_VTX_W-1:0] vertex_index,
	output logic                           is_new,
	output logic                           overflow
);

	import vidm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_HASH  = 2'd2;
	localparam logic [1:0] ST_PROBE = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           state_d;
	logic [SLOT_W-1:0]    clr_cnt_q;
	logic                 pend_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [NV_W-1:0]      nv_q;
	logic [KEY_W-1:0]     key_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    slot_d;
	logic [SLOT_W-1:0]    probe_q;
	logic                 out_valid_q;
	logic [OUT_VTX_W-1:0] vertex_index_q;
	logic                 is_new_q;
	logic                 overflow_q;

	logic                 accept;
	logic                 epoch_wrap;
	logic                 clear_done;
	logic                 hash_start;
	logic                 hash_done;
	logic [SLOT_W-1:0]    hash_slot;
	logic                 out_free;
	logic                 ent_live;
	logic                 ent_hit;
	logic                 chain_end;
	logic                 space_full;
	logic                 do_result;
	logic                 do_insert;
	logic                 do_advance;
	logic                 ram_we;
	logic [SLOT_W-1:0]    ram_waddr;
	slot_entry_t          ram_wdata;
	slot_entry_t          ram_rdata;

	assign accept     = in_valid && in_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign epoch_wrap = clear_map && (epoch_q == {EPOCH_W{1'b1}});
	assign clear_done = (state_q == ST_CLEAR) && (clr_cnt_q == SLOT_W'(TABLE_SLOTS - 1));
	assign hash_start = (accept && !epoch_wrap) || (clear_done && pend_q);

	// Probe decision on the entry read for the current slot.
	assign out_free   = !out_valid_q || out_ready;
	assign ent_live   = (ram_rdata.epoch == epoch_q);
	assign ent_hit    = ent_live && (ram_rdata.key == key_q);
	assign chain_end  = (probe_q == SLOT_W'(TABLE_SLOTS - 1));
	assign space_full = (nv_q == NV_W'(VCAP));
	assign do_advance = (state_q == ST_PROBE) && ent_live && !ent_hit && !chain_end;
	assign do_result  = (state_q == ST_PROBE) && out_free && !do_advance;
	assign do_insert  = do_result && !ent_live && !space_full;

	// Next slot, which is also the read address, so that the registered read
	// data belongs to the current slot_q.
	always_comb begin
		slot_d = slot_q;
		if ((state_q == ST_HASH) && hash_done) begin
			slot_d = hash_slot;
		end else if (do_advance) begin
			slot_d = slot_q + 1'b1;
		end
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = epoch_wrap ? ST_CLEAR : ST_HASH;
				end
			end
			ST_CLEAR: begin
				if (clear_done) begin
					state_d = pend_q ? ST_HASH : ST_IDLE;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (do_result) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			pend_q    <= 1'b0;
			epoch_q   <= EPOCH_W'(1);
			nv_q      <= '0;
			slot_q    <= '0;
			probe_q   <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (clear_done) begin
				pend_q <= 1'b0;
			end
			if (accept && clear_map) begin
				nv_q <= '0;
				if (epoch_wrap) begin
					epoch_q <= EPOCH_W'(1);
					pend_q  <= 1'b1;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
			if ((state_q == ST_HASH) && hash_done) begin
				probe_q <= '0;
			end else if (do_advance) begin
				probe_q <= probe_q + 1'b1;
			end
			if (do_insert) begin
				nv_q <= nv_q + 1'b1;
			end
		end
	end

	// Key capture on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {normal_index[INDEX_BITS-1:0], texcoord_index[INDEX_BITS-1:0],
				position_index[INDEX_BITS-1:0]};
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_result) begin
			if (ent_hit) begin
				vertex_index_q <= OUT_VTX_W'(ram_rdata.vertex);
				is_new_q       <= 1'b0;
				overflow_q     <= 1'b0;
			end else if (do_insert) begin
				vertex_index_q <= OUT_VTX_W'(nv_q);
				is_new_q       <= 1'b1;
				overflow_q     <= 1'b0;
			end else begin
				vertex_index_q <= '0;
				is_new_q       <= 1'b0;
				overflow_q     <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign is_new       = is_new_q;
	assign overflow     = overflow_q;

	// Write port: the clearing pass marks every entry with the stale epoch,
	// an insert stores key and vertex under the running epoch.
	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = slot_q;
		ram_wdata.epoch  = epoch_q;
		ram_wdata.key    = key_q;
		ram_wdata.vertex = VTX_W'(nv_q);
		if (state_q == ST_CLEAR) begin
			ram_we           = 1'b1;
			ram_waddr        = clr_cnt_q;
			ram_wdata.epoch  = '0;
			ram_wdata.key    = '0;
			ram_wdata.vertex = '0;
		end else if (do_insert) begin
			ram_we = 1'b1;
		end
	end

	vidm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (PROD_W'(key_q)),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	vidm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot_d),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(is_new_q && overflow_q))
		else $error("is_new and overflow set in the same word");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overflow_q) |-> (vertex_index_q == '0))
		else $error("overflow word carries a nonzero index");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nv_q <= NV_W'(VCAP))
		else $error("vertex counter beyond the index space");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && clear_map) |=> (nv_q == '0))
		else $error("clear did not reset the vertex counter");

	a_new_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (nv_q == $past(nv_q) + 1'b1))
		else $error("insert did not advance the vertex counter");
`endif

endmodule

@@ rtl/core/vidm_ram.sv @@
module vidm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/vidm_hash.sv @@
module vidm_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vidm_pkg::PROD_W-1:0] key,
	output logic                        done,
	output logic [vidm_pkg::SLOT_W-1:0] slot
);

	import vidm_pkg::*;

	localparam logic [MUL_W-1:0] MULT_LO = HASH_MULT[MUL_W-1:0];
	localparam logic [MUL_W-1:0] MULT_HI = HASH_MULT[PROD_W-1:MUL_W];

	logic              busy_q;
	logic [1:0]        phase_q;
	logic              done_q;
	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] prod_shifted;

	// Operand select for the shared multiplier: low by low, low by high,
	// high by low. The high by high term falls outside the kept bits.
	assign op_a = (phase_q == 2'd2) ? key[PROD_W-1:MUL_W] : key[MUL_W-1:0];
	assign op_b = (phase_q == 2'd1) ? MULT_HI : MULT_LO;
	assign prod_shifted = {prod_q[MUL_W-1:0], {MUL_W{1'b0}}};

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Product register and accumulator, one partial product a cycle.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_q <= op_a * op_b;
			case (phase_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_q;
				2'd2: acc_q <= acc_q + prod_shifted;
				2'd3: acc_q <= acc_q + prod_shifted;
				default: acc_q <= acc_q;
			endcase
		end
	end

	// Fold the upper half onto the lower one and keep the slot bits.
	assign slot = acc_q[SLOT_W-1:0] ^ acc_q[SLOT_W+31:32];
	assign done = done_q;

endmodule

@@ tb/vidm_corner_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the vertex dedup map, keeps its own hash table
// of the current mesh and checks every result word against the oldest
// prediction still waiting.
module vidm_corner_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [vidm_pkg::FIELD_W-1:0]   position_index,
	input  logic [vidm_pkg::FIELD_W-1:0]   texcoord_index,
	input  logic [vidm_pkg::FIELD_W-1:0]   normal_index,
	input  logic                           clear_map,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [vidm_pkg::OUT_VTX_W-1:0] vertex_index,
	input  logic                           is_new,
	input  logic                           overflow,
	output int                             fail_count,
	output int                             pending
);

	localparam int SLOTS     = vidm_pkg::TABLE_SLOTS;
	localparam int VERT_CAP  = vidm_pkg::MAX_VERTICES;
	localparam int IDX_BITS  = vidm_pkg::INDEX_BITS;

	typedef logic [vidm_pkg::KEY_W-1:0]     corner_key_t;
	typedef logic [vidm_pkg::FIELD_W-1:0]   field_t;
	typedef logic [vidm_pkg::OUT_VTX_W-1:0] vertex_t;

	typedef struct packed {
		vertex_t vertex;
		logic    fresh;
		logic    full;
	} vertex_result_t;

	// Shadow of the slot table for the current mesh.
	corner_key_t slot_key [SLOTS];
	bit          slot_used [SLOTS];
	int unsigned slot_vtx [SLOTS];
	int unsigned vertex_count;

	vertex_result_t queued_vertex_results[$];

	// Tallies for the end-of-run summary.
	int n_new;
	int n_hit;
	int n_over;
	int n_clear;
	int deepest_probe;

	function automatic corner_key_t pack_key(input field_t pos, input field_t tex,
			input field_t nrm);
		corner_key_t lane_mask;
		lane_mask = (corner_key_t'(1) << IDX_BITS) - corner_key_t'(1);
		return (corner_key_t'(pos) & lane_mask)
			| ((corner_key_t'(tex) & lane_mask) << IDX_BITS)
			| ((corner_key_t'(nrm) & lane_mask) << (2 * IDX_BITS));
	endfunction

	// Multiplicative hash folded onto itself, then reduced to a slot number.
	function automatic int unsigned home_slot(input corner_key_t key);
		logic [63:0] mixed;
		mixed = 64'(key) * vidm_pkg::HASH_MULT;
		mixed = mixed ^ (mixed >> 32);
		return int'(mixed % 64'(SLOTS));
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++)
			slot_used[i] = 1'b0;
		vertex_count = 0;
	endfunction

	// Linear probe from the home slot: a hit returns the stored index, an empty
	// slot takes the next free index unless the vertex space is used up.
	function automatic vertex_result_t lookup_corner(input field_t pos, input field_t tex,
			input field_t nrm, input logic clr);
		corner_key_t    key;
		int unsigned    slot;
		int unsigned    probes;
		vertex_result_t res;
		if (clr) begin
			wipe_table();
			n_clear++;
		end
		key = pack_key(pos, tex, nrm);
		slot = home_slot(key);
		for (probes = 0; probes < SLOTS; probes++) begin
			if (!slot_used[slot])
				break;
			if (slot_key[slot] == key) begin
				res.vertex = vertex_t'(slot_vtx[slot]);
				res.fresh = 1'b0;
				res.full = 1'b0;
				n_hit++;
				if (probes > deepest_probe)
					deepest_probe = probes;
				return res;
			end
			slot = (slot + 1) % SLOTS;
		end
		if (probes > deepest_probe)
			deepest_probe = probes;
		if (vertex_count >= VERT_CAP || vertex_count >= SLOTS || probes >= SLOTS) begin
			res.vertex = '0;
			res.fresh = 1'b0;
			res.full = 1'b1;
			n_over++;
			return res;
		end
		slot_used[slot] = 1'b1;
		slot_key[slot] = key;
		slot_vtx[slot] = vertex_count;
		res.vertex = vertex_t'(vertex_count);
		res.fresh = 1'b1;
		res.full = 1'b0;
		vertex_count++;
		n_new++;
		return res;
	endfunction

	always @(posedge clk) begin
		vertex_result_t want;
		vertex_result_t predicted;
		if (!arst_n) begin
			wipe_table();
			queued_vertex_results.delete();
		end else begin
			// Compare each result word with the oldest prediction.
			if (out_valid && out_ready) begin
				if (queued_vertex_results.size() == 0) begin
					$display("%0t: result word with none expected: vertex_index %0d is_new %b overflow %b",
						$time, vertex_index, is_new, overflow);
					fail_count++;
				end else begin
					want = queued_vertex_results.pop_front();
					if (vertex_index !== want.vertex) begin
						$display("%0t: vertex_index expected %0d, actual %0d",
							$time, want.vertex, vertex_index);
						fail_count++;
					end
					if (is_new !== want.fresh) begin
						$display("%0t: is_new expected %b, actual %b", $time, want.fresh, is_new);
						fail_count++;
					end
					if (overflow !== want.full) begin
						$display("%0t: overflow expected %b, actual %b",
							$time, want.full, overflow);
						fail_count++;
					end
				end
			end
			// Predict the result of each corner word taken in.
			if (in_valid && in_ready) begin
				predicted = lookup_corner(position_index, texcoord_index,
					normal_index, clear_map);
				queued_vertex_results = {queued_vertex_results, predicted};
			end
		end
		pending <= queued_vertex_results.size();
	end

endmodule

@@ tb/tb_vertex_index_dedup_map.sv @@
`timescale 1ns / 100ps

module tb_vertex_index_dedup_map;

	import vidm_pkg::*;

	typedef logic [FIELD_W-1:0] field_t;

	localparam int     FIELD_MAX      = (1 << FIELD_W) - 1;
	localparam field_t FIELD_ONES     = '1;
	// Enough mesh clears to carry the block past one wrap of its mesh epoch.
	localparam int     CLEARS_TO_WRAP = 260;

	typedef struct packed {
		field_t pos;
		field_t tex;
		field_t nrm;
	} corner_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	field_t               position_index = '0;
	field_t               texcoord_index = '0;
	field_t               normal_index = '0;
	logic                 clear_map = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OUT_VTX_W-1:0] vertex_index;
	logic                 is_new;
	logic                 overflow;

	int fail_count;
	int pending;

	int idle_pct = 0;
	int stall_left = 0;
	int clears_sent = 0;
	int corners_sent = 0;
	corner_t mesh_keys[$];

	vertex_index_dedup_map DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.position_index (position_index),
		.texcoord_index (texcoord_index),
		.normal_index   (normal_index),
		.clear_map      (clear_map),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.vertex_index   (vertex_index),
		.is_new         (is_new),
		.overflow       (overflow)
	);

	vidm_corner_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.position_index (position_index),
		.texcoord_index (texcoord_index),
		.normal_index   (normal_index),
		.clear_map      (clear_map),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.vertex_index   (vertex_index),
		.is_new         (is_new),
		.overflow       (overflow),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// The result side stalls in random bursts when idle_pct is nonzero.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one corner word, after an optional idle burst, and hold it until taken.
	task automatic send_corner(input corner_t c, input logic clr);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		position_index <= c.pos;
		texcoord_index <= c.tex;
		normal_index <= c.nrm;
		clear_map <= clr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (clr) begin
			mesh_keys.delete();
			clears_sent++;
		end
		mesh_keys = {mesh_keys, c};
		corners_sent++;
	endtask

	function automatic corner_t rand_corner(input int unsigned span);
		corner_t c;
		c.pos = field_t'($urandom_range(0, span));
		c.tex = field_t'($urandom_range(0, span));
		c.nrm = field_t'($urandom_range(0, span));
		return c;
	endfunction

	function automatic corner_t mesh_corner();
		return mesh_keys[$urandom_range(0, mesh_keys.size() - 1)];
	endfunction

	// Search for a random triple whose hash lands on the given slot.
	function automatic corner_t find_corner_at(input int unsigned target);
		corner_t c;
		do
			c = rand_corner(FIELD_MAX);
		while (chk.home_slot(chk.pack_key(c.pos, c.tex, c.nrm)) != target);
		return c;
	endfunction

	initial begin
		corner_t chain[3];
		int unsigned roll;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, hits, a probe chain across the table end,
		// and a mesh clear that must hide the earlier entries.
		idle_pct = 20;
		send_corner('{'0, '0, '0}, 1'b0);
		send_corner('{'0, '0, '0}, 1'b0);
		send_corner('{FIELD_ONES, FIELD_ONES, FIELD_ONES}, 1'b0);
		send_corner('{FIELD_ONES, '0, '0}, 1'b0);
		send_corner('{'0, FIELD_ONES, '0}, 1'b0);
		send_corner('{'0, '0, FIELD_ONES}, 1'b0);
		send_corner('{21'h155555, 21'h0AAAAA, 21'h155555}, 1'b0);
		send_corner('{21'h0AAAAA, 21'h155555, 21'h0AAAAA}, 1'b0);
		send_corner('{FIELD_ONES, FIELD_ONES, FIELD_ONES}, 1'b0);
		for (int i = 0; i < 3; i++)
			chain[i] = find_corner_at(TABLE_SLOTS - 1);
		for (int i = 0; i < 3; i++)
			send_corner(chain[i], 1'b0);
		for (int i = 2; i >= 0; i--)
			send_corner(chain[i], 1'b0);
		send_corner('{'0, '0, '0}, 1'b1);
		send_corner('{FIELD_ONES, FIELD_ONES, FIELD_ONES}, 1'b0);
		send_corner('{'0, '0, '0}, 1'b0);

		// Random meshes: repeats of earlier corners, small indices that collide
		// often, full-range triples and the odd clear.
		idle_pct = 30;
		for (int i = 0; i < 100; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				send_corner(rand_corner(FIELD_MAX), 1'b1);
			else if (roll < 48 && mesh_keys.size() > 0)
				send_corner(mesh_corner(), 1'b0);
			else if (roll < 70)
				send_corner(rand_corner(15), 1'b0);
			else
				send_corner(rand_corner(FIELD_MAX), 1'b0);
		end

		// Many tiny meshes over a handful of triples, so that stale entries of
		// old meshes sit in the table while the mesh epoch wraps around.
		idle_pct = 25;
		while (clears_sent < CLEARS_TO_WRAP) begin
			send_corner(rand_corner(3), 1'b1);
			if ($urandom_range(0, 7) == 0)
				send_corner(mesh_corner(), 1'b0);
		end

		// Last stretch with no idling: repeats and new triples offered back to
		// back in the mesh left after the wrap.
		idle_pct = 0;
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 1) == 0)
				send_corner(mesh_corner(), 1'b0);
			else
				send_corner(rand_corner(FIELD_MAX), 1'b0);
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);

		$display("Sent %0d corner words over %0d mesh clears: %0d new, %0d repeated, %0d overflow.",
			corners_sent, chk.n_clear, chk.n_new, chk.n_hit, chk.n_over);
		$display("Longest predicted probe chain: %0d slots past home.", chk.deepest_probe);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
